@@ src/heap_pressure_restart_monitor_macros.svh @@
// assertion macros for the heap pressure restart monitor
// expects signals clk and arst_n in the including module
`ifndef HEAP_PRESSURE_RESTART_MONITOR_MACROS_SVH
`define HEAP_PRESSURE_RESTART_MONITOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define HPRM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define HPRM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/hprm_pkg.sv @@
// shared constants, codes and types for the heap pressure restart monitor
// no dependencies
package hprm_pkg;

	localparam int RING_DEPTH        = 12;
	localparam int MIN_TREND_SAMPLES = 6;
	localparam int BURST_SUPPRESS_S  = 14400;

	localparam int FILL_W   = $clog2(RING_DEPTH + 1);
	localparam int SAMPLE_W = 16;

	// event kinds carried in s_tuser
	localparam logic [1:0] FUNC_SAMPLE    = 2'd0;
	localparam logic [1:0] FUNC_CHECK     = 2'd1;
	localparam logic [1:0] FUNC_HEARTBEAT = 2'd2;
	localparam logic [1:0] FUNC_FLUSH     = 2'd3;

	// register indexes (byte address is 4 * index)
	localparam logic [2:0] REG_PRESSURE_THRESHOLD  = 3'd0;
	localparam logic [2:0] REG_DEBOUNCE_SAMPLES    = 3'd1;
	localparam logic [2:0] REG_MIN_UPTIME          = 3'd2;
	localparam logic [2:0] REG_EROSION_DELTA       = 3'd3;
	localparam logic [2:0] REG_COMPACT_ENTER_FREE  = 3'd4;
	localparam logic [2:0] REG_COMPACT_ENTER_BLOCK = 3'd5;
	localparam logic [2:0] REG_COMPACT_EXIT_FREE   = 3'd6;
	localparam logic [2:0] REG_COMPACT_EXIT_BLOCK  = 3'd7;

	// register reset values
	localparam logic [15:0] RST_PRESSURE_THRESHOLD  = 16'd13000;
	localparam logic [3:0]  RST_DEBOUNCE_SAMPLES    = 4'd3;
	localparam logic [15:0] RST_MIN_UPTIME          = 16'd1800;
	localparam logic [15:0] RST_EROSION_DELTA       = 16'd1024;
	localparam logic [16:0] RST_COMPACT_ENTER_FREE  = 17'd20000;
	localparam logic [16:0] RST_COMPACT_ENTER_BLOCK = 17'd14000;
	localparam logic [16:0] RST_COMPACT_EXIT_FREE   = 17'd21024;
	localparam logic [16:0] RST_COMPACT_EXIT_BLOCK  = 17'd15024;

	// one result, restart_request in the lowest bit
	typedef struct packed {
		logic [3:0] samples_held;
		logic [3:0] pressure_count;
		logic       compact_mode;
		logic       restart_request;
	} result_t;

endpackage

@@ src/hprm_cell.sv @@
// one ring cell: holds a sample, passes it on when a new sample shifts in
// depends on hprm_pkg
module hprm_cell (
	input  logic                          clk,
	input  logic                          shift,
	input  logic [hprm_pkg::SAMPLE_W-1:0] d,
	input  logic                          sel,
	input  logic [hprm_pkg::SAMPLE_W-1:0] pick_in,
	output logic [hprm_pkg::SAMPLE_W-1:0] q,
	output logic [hprm_pkg::SAMPLE_W-1:0] pick_out
);

	logic [hprm_pkg::SAMPLE_W-1:0] sample_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			sample_q <= d;
		end
	end

	assign q        = sample_q;
	// the selected cell drops its sample onto the pick chain
	assign pick_out = pick_in | (sel ? sample_q : '0);

endmodule

@@ src/hprm_skid.sv @@
// two-entry output stage: result register plus skid register
// depends on hprm_pkg
module hprm_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  hprm_pkg::result_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output hprm_pkg::result_t out_data
);

	logic              out_valid_q;
	hprm_pkg::result_t out_q;
	logic              skid_valid_q;
	hprm_pkg::result_t skid_q;
	logic              in_fire;
	logic              out_fire;

	assign in_ready = !skid_valid_q;
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_fire) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_fire;
			end
		end else if (in_fire) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire) begin
			out_q <= skid_valid_q ? skid_q : in_data;
		end else if (in_fire) begin
			if (out_valid_q) begin
				skid_q <= in_data;
			end else begin
				out_q <= in_data;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ src/heap_pressure_restart_monitor.sv @@
// top level of the heap pressure restart monitor: registers, event logic, ring of cells
// depends on hprm_pkg, hprm_cell, hprm_skid and heap_pressure_restart_monitor_macros.svh
//
//  channel   | ports                                  | moves
//  ----------+----------------------------------------+-------------------------------
//  events in | s_tvalid s_tready s_tdata s_tuser      | one event per transaction
//  result    | m_tvalid m_tready m_tdata              | one result per event
//  registers | psel penable pwrite paddr pwdata prdata| APB writes and reads
//
// an event is decided in the cycle it is accepted; its result is registered in the
// output stage; one event per cycle sustained while m_tready stays high
// the sample ring is a row of cells that shift together on each sample event; the
// oldest sample is picked by a select chain running through the cells
// reset clears the fill count, debounce count, compact latch and output stage; the
// registers return to their defaults; cell contents stay undefined until written
// a stalled result sits in the output register and a second one in the skid
// register; s_tready drops only while both are occupied
`include "heap_pressure_restart_monitor_macros.svh"

module heap_pressure_restart_monitor (
	input  logic        clk,
	input  logic        arst_n,
	// events
	input  logic        s_tvalid,
	output logic        s_tready,
	// block_bytes[16:0], free_bytes[33:17], uptime[65:34],
	// recovery_active[66], prior_was_proactive[67], zero pad[71:68]
	input  logic [71:0] s_tdata,
	// func[1:0]
	input  logic [1:0]  s_tuser,
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	// restart_request[0], compact_mode[1], pressure_count[5:2],
	// samples_held[9:6], zero pad[15:10]
	output logic [15:0] m_tdata,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int DEPTH = hprm_pkg::RING_DEPTH;
	localparam int FW    = hprm_pkg::FILL_W;
	localparam int SW    = hprm_pkg::SAMPLE_W;

	// configuration registers
	logic [15:0] pressure_threshold_q;
	logic [3:0]  debounce_samples_q;
	logic [15:0] min_uptime_q;
	logic [15:0] erosion_delta_q;
	logic [16:0] compact_enter_free_q;
	logic [16:0] compact_enter_block_q;
	logic [16:0] compact_exit_free_q;
	logic [16:0] compact_exit_block_q;

	// block state
	logic [FW-1:0] fill_q;
	logic [3:0]    low_q;
	logic          latch_q;

	// unpacked event fields
	logic [1:0]  func;
	logic [16:0] block_bytes;
	logic [16:0] free_bytes;
	logic [31:0] uptime;
	logic        recovery_active;
	logic        prior_was_proactive;

	logic              s_fire;
	logic              cfg_wr;
	logic [2:0]        cfg_idx;
	hprm_pkg::result_t res;
	hprm_pkg::result_t out_res;

	logic [FW-1:0] fill_nxt;
	logic [3:0]    low_nxt;
	logic          latch_nxt;
	logic          fire;

	// ring of cells
	logic [SW-1:0] cell_d [DEPTH];
	logic [SW-1:0] cell_q [DEPTH];
	logic [SW-1:0] pick   [DEPTH+1];
	logic          sel    [DEPTH];
	logic [SW-1:0] sat_sample;
	logic          shift;
	logic [SW-1:0] oldest;
	logic [SW-1:0] newest;
	logic          not_eroding;
	logic          gated;

	assign func                = s_tuser;
	assign block_bytes         = s_tdata[16:0];
	assign free_bytes          = s_tdata[33:17];
	assign uptime              = s_tdata[65:34];
	assign recovery_active     = s_tdata[66];
	assign prior_was_proactive = s_tdata[67];

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressure_threshold_q  <= hprm_pkg::RST_PRESSURE_THRESHOLD;
			debounce_samples_q    <= hprm_pkg::RST_DEBOUNCE_SAMPLES;
			min_uptime_q          <= hprm_pkg::RST_MIN_UPTIME;
			erosion_delta_q       <= hprm_pkg::RST_EROSION_DELTA;
			compact_enter_free_q  <= hprm_pkg::RST_COMPACT_ENTER_FREE;
			compact_enter_block_q <= hprm_pkg::RST_COMPACT_ENTER_BLOCK;
			compact_exit_free_q   <= hprm_pkg::RST_COMPACT_EXIT_FREE;
			compact_exit_block_q  <= hprm_pkg::RST_COMPACT_EXIT_BLOCK;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				hprm_pkg::REG_PRESSURE_THRESHOLD:  pressure_threshold_q  <= pwdata[15:0];
				hprm_pkg::REG_DEBOUNCE_SAMPLES:    debounce_samples_q    <= pwdata[3:0];
				hprm_pkg::REG_MIN_UPTIME:          min_uptime_q          <= pwdata[15:0];
				hprm_pkg::REG_EROSION_DELTA:       erosion_delta_q       <= pwdata[15:0];
				hprm_pkg::REG_COMPACT_ENTER_FREE:  compact_enter_free_q  <= pwdata[16:0];
				hprm_pkg::REG_COMPACT_ENTER_BLOCK: compact_enter_block_q <= pwdata[16:0];
				hprm_pkg::REG_COMPACT_EXIT_FREE:   compact_exit_free_q   <= pwdata[16:0];
				hprm_pkg::REG_COMPACT_EXIT_BLOCK:  compact_exit_block_q  <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			hprm_pkg::REG_PRESSURE_THRESHOLD:  prdata = {16'd0, pressure_threshold_q};
			hprm_pkg::REG_DEBOUNCE_SAMPLES:    prdata = {28'd0, debounce_samples_q};
			hprm_pkg::REG_MIN_UPTIME:          prdata = {16'd0, min_uptime_q};
			hprm_pkg::REG_EROSION_DELTA:       prdata = {16'd0, erosion_delta_q};
			hprm_pkg::REG_COMPACT_ENTER_FREE:  prdata = {15'd0, compact_enter_free_q};
			hprm_pkg::REG_COMPACT_ENTER_BLOCK: prdata = {15'd0, compact_enter_block_q};
			hprm_pkg::REG_COMPACT_EXIT_FREE:   prdata = {15'd0, compact_exit_free_q};
			hprm_pkg::REG_COMPACT_EXIT_BLOCK:  prdata = {15'd0, compact_exit_block_q};
			default:                           prdata = '0;
		endcase
	end

	// ---------------- sample ring ----------------
	// saturate the reading to 16 bits
	assign sat_sample = block_bytes[16] ? {SW{1'b1}} : block_bytes[15:0];
	assign shift      = s_fire && (func == hprm_pkg::FUNC_SAMPLE);
	assign pick[0]    = '0;

	// newest sample in cell 0; oldest in cell fill-1
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign cell_d[i] = sat_sample;
		end else begin : g_body
			assign cell_d[i] = cell_q[i-1];
		end
		assign sel[i] = (fill_q == FW'(i + 1));

		hprm_cell u_cell (
			.clk      (clk),
			.shift    (shift),
			.d        (cell_d[i]),
			.sel      (sel[i]),
			.pick_in  (pick[i]),
			.q        (cell_q[i]),
			.pick_out (pick[i+1])
		);
	end

	assign oldest = pick[DEPTH];
	assign newest = cell_q[0];

	// too few samples reads as erosion
	assign not_eroding = (32'(fill_q) >= hprm_pkg::MIN_TREND_SAMPLES) &&
		((newest >= oldest) || ((oldest - newest) < erosion_delta_q));

	assign gated = (uptime < {16'd0, min_uptime_q}) || recovery_active ||
		(prior_was_proactive && (uptime < 32'(hprm_pkg::BURST_SUPPRESS_S)));

	// ---------------- event decision ----------------
	always_comb begin
		fill_nxt  = fill_q;
		low_nxt   = low_q;
		latch_nxt = latch_q;
		fire      = 1'b0;
		unique case (func)
			hprm_pkg::FUNC_SAMPLE: begin
				if (32'(fill_q) < DEPTH) begin
					fill_nxt = fill_q + 1'b1;
				end
			end
			hprm_pkg::FUNC_CHECK: begin
				priority if (gated) begin
					low_nxt = low_q;
				end else if (block_bytes >= {1'b0, pressure_threshold_q}) begin
					low_nxt = '0;
				end else if (low_q < debounce_samples_q) begin
					low_nxt = low_q + 1'b1;
				end else if (not_eroding) begin
					low_nxt = '0;
				end else begin
					fire = 1'b1;
				end
			end
			hprm_pkg::FUNC_HEARTBEAT: begin
				// hysteresis: separate enter and exit levels
				if (latch_q) begin
					if (free_bytes >= compact_exit_free_q &&
						block_bytes >= compact_exit_block_q) begin
						latch_nxt = 1'b0;
					end
				end else if (free_bytes < compact_enter_free_q ||
					block_bytes < compact_enter_block_q) begin
					latch_nxt = 1'b1;
				end
			end
			hprm_pkg::FUNC_FLUSH: begin
				fill_nxt = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			low_q   <= '0;
			latch_q <= 1'b0;
		end else if (s_fire) begin
			fill_q  <= fill_nxt;
			low_q   <= low_nxt;
			latch_q <= latch_nxt;
		end
	end

	assign res.restart_request = fire;
	assign res.compact_mode    = latch_nxt;
	assign res.pressure_count  = low_nxt;
	assign res.samples_held    = 4'(fill_nxt);

	// ---------------- output stage ----------------
	hprm_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign s_fire  = s_tvalid && s_tready;
	assign m_tdata = {6'd0, out_res};

	// ---------------- assertions ----------------
	`HPRM_ASSERT_IMP(a_fill_bound, 1'b1, 32'(fill_q) <= DEPTH, "ring fill above depth")
	`HPRM_ASSERT_IMP(a_fire_only_check, s_fire && (func != hprm_pkg::FUNC_CHECK),
		!res.restart_request, "restart request outside a check")
	`HPRM_ASSERT_NXT(a_fill_step, shift && (32'(fill_q) < DEPTH),
		fill_q == $past(fill_q) + 1'b1, "sample did not grow the ring fill")
	`HPRM_ASSERT_NXT(a_flush_empty, s_fire && (func == hprm_pkg::FUNC_FLUSH),
		fill_q == '0, "flush left samples in the ring")

endmodule

@@ dv/hprm_result_checker.sv @@
// result checker for the heap pressure restart monitor: mirrors the block's state,
// predicts one result per accepted event and compares results in order
// depends on hprm_pkg; watches the event, result and register channels of the block
module hprm_result_checker
	import hprm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// block_bytes[16:0], free_bytes[33:17], uptime[65:34],
	// recovery_active[66], prior_was_proactive[67], zero pad[71:68]
	input  logic [71:0] s_tdata,
	// func[1:0]
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// restart_request[0], compact_mode[1], pressure_count[5:2],
	// samples_held[9:6], zero pad[15:10]
	input  logic [15:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          errors,
	output int          pending
);

	// mirrored registers
	logic [15:0] pressure_thr;
	logic [3:0]  debounce_lim;
	logic [15:0] min_uptime;
	logic [15:0] erosion_min;
	logic [16:0] enter_free, enter_block, exit_free, exit_block;

	// mirrored state
	logic [15:0] ring [RING_DEPTH];
	int unsigned head, fill;
	logic [3:0]  low_cnt;
	logic        latch;

	result_t awaited_results[$];
	result_t got, want;

	task automatic report(input string what, input int got_v, input int want_v);
		$display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got_v, want_v);
		errors++;
	endtask

	// no erosion: enough samples and newest not far enough below oldest
	function automatic bit trend_is_flat();
		int unsigned oldest, newest;
		logic [15:0] old_v, new_v;
		if (fill < MIN_TREND_SAMPLES)
			return 1'b0;
		oldest = (head + RING_DEPTH - fill) % RING_DEPTH;
		newest = (head + RING_DEPTH - 1) % RING_DEPTH;
		old_v = ring[oldest];
		new_v = ring[newest];
		if (new_v >= old_v)
			return 1'b1;
		return (old_v - new_v) < erosion_min;
	endfunction

	function automatic bit decide_restart(input logic [16:0] blk, input logic [31:0] up,
			input logic rec, input logic pri);
		if (up < 32'(min_uptime))
			return 1'b0;
		if (rec)
			return 1'b0;
		if (pri && up < 32'(BURST_SUPPRESS_S))
			return 1'b0;
		if (blk >= 17'(pressure_thr)) begin
			low_cnt = '0;
			return 1'b0;
		end
		if (low_cnt < debounce_lim) begin
			low_cnt++;
			return 1'b0;
		end
		if (trend_is_flat()) begin
			low_cnt = '0;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic result_t predict_event(input logic [1:0] kind, input logic [71:0] d);
		result_t r;
		logic [16:0] blk, freeb;
		logic [31:0] up;
		logic fire;
		blk = d[16:0];
		freeb = d[33:17];
		up = d[65:34];
		fire = 1'b0;
		case (kind)
			FUNC_SAMPLE: begin
				ring[head] = (blk > 17'd65535) ? 16'hFFFF : blk[15:0];
				head = (head + 1) % RING_DEPTH;
				if (fill < RING_DEPTH)
					fill++;
			end
			FUNC_CHECK: begin
				fire = decide_restart(blk, up, d[66], d[67]);
			end
			FUNC_HEARTBEAT: begin
				if (latch) begin
					if (freeb >= exit_free && blk >= exit_block)
						latch = 1'b0;
				end else if (freeb < enter_free || blk < enter_block) begin
					latch = 1'b1;
				end
			end
			default: begin
				head = 0;
				fill = 0;
			end
		endcase
		r.restart_request = fire;
		r.compact_mode = latch;
		r.pressure_count = low_cnt;
		r.samples_held = 4'(fill);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressure_thr = RST_PRESSURE_THRESHOLD;
			debounce_lim = RST_DEBOUNCE_SAMPLES;
			min_uptime = RST_MIN_UPTIME;
			erosion_min = RST_EROSION_DELTA;
			enter_free = RST_COMPACT_ENTER_FREE;
			enter_block = RST_COMPACT_ENTER_BLOCK;
			exit_free = RST_COMPACT_EXIT_FREE;
			exit_block = RST_COMPACT_EXIT_BLOCK;
			head = 0;
			fill = 0;
			low_cnt = '0;
			latch = 1'b0;
			awaited_results.delete();
			pending <= 0;
		end else begin
			// results first: a result never leaves in the cycle of its own event
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[9:0]);
				if (awaited_results.size() == 0) begin
					report("result with no event pending", int'(m_tdata), 0);
				end else begin
					want = awaited_results.pop_front();
					if (got.restart_request !== want.restart_request)
						report("restart_request", int'(got.restart_request),
							int'(want.restart_request));
					if (got.compact_mode !== want.compact_mode)
						report("compact_mode", int'(got.compact_mode),
							int'(want.compact_mode));
					if (got.pressure_count !== want.pressure_count)
						report("pressure_count", int'(got.pressure_count),
							int'(want.pressure_count));
					if (got.samples_held !== want.samples_held)
						report("samples_held", int'(got.samples_held),
							int'(want.samples_held));
					if (m_tdata[15:10] !== 6'd0)
						report("m_tdata pad bits", int'(m_tdata[15:10]), 0);
				end
			end
			if (s_tvalid && s_tready)
				awaited_results.push_back(predict_event(s_tuser, s_tdata));
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_PRESSURE_THRESHOLD:  pressure_thr = pwdata[15:0];
					REG_DEBOUNCE_SAMPLES:    debounce_lim = pwdata[3:0];
					REG_MIN_UPTIME:          min_uptime = pwdata[15:0];
					REG_EROSION_DELTA:       erosion_min = pwdata[15:0];
					REG_COMPACT_ENTER_FREE:  enter_free = pwdata[16:0];
					REG_COMPACT_ENTER_BLOCK: enter_block = pwdata[16:0];
					REG_COMPACT_EXIT_FREE:   exit_free = pwdata[16:0];
					REG_COMPACT_EXIT_BLOCK:  exit_block = pwdata[16:0];
					default: ;
				endcase
			end
			pending <= awaited_results.size();
		end
	end

endmodule

@@ dv/tb_top.sv @@
// testbench top for the heap pressure restart monitor: clock, reset, event stimulus,
// register phases, result back-pressure and the final verdict
// depends on hprm_pkg, heap_pressure_restart_monitor and hprm_result_checker
module tb_top;
	import hprm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// block_bytes[16:0], free_bytes[33:17], uptime[65:34],
	// recovery_active[66], prior_was_proactive[67], zero pad[71:68]
	logic [71:0] s_tdata;
	// func[1:0]
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// restart_request[0], compact_mode[1], pressure_count[5:2],
	// samples_held[9:6], zero pad[15:10]
	logic [15:0] m_tdata;
	logic        psel, penable, pwrite, pready;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;

	int errors, pending;
	int cycle_count = 0;
	int sent_items = 0;
	bit tx_steady = 1'b0;

	// shadow of the register settings, only used to aim the stimulus
	int cfg_thr, cfg_deb, cfg_min;
	int cfg_enter_free, cfg_enter_block, cfg_exit_free, cfg_exit_block;

	heap_pressure_restart_monitor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	hprm_result_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.pready   (pready),
		.errors   (errors),
		.pending  (pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// hard stop in case the block hangs on either handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side: random stall per transaction, steady stretches, and two long
	// hold-offs so that both output registers fill and s_tready drops
	initial begin : result_sink
		int gap, taken;
		bit steady;
		taken = 0;
		steady = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken % 40 == 0)
				steady = ($urandom_range(0, 2) == 0);
			gap = steady ? 0 : $urandom_range(0, 3);
			if (taken == 300 || taken == 900)
				gap = 64;
			if (gap > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			taken++;
		end
	end

	// one event transaction; tvalid stays high between back-to-back events
	task automatic push_event(input logic [1:0] kind, input logic [16:0] blk,
			input logic [16:0] freeb, input logic [31:0] up, input logic rec, input logic pri);
		int gap;
		if (sent_items % 50 == 0)
			tx_steady = ($urandom_range(0, 2) == 0);
		gap = tx_steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {4'b0, pri, rec, up, freeb, blk};
		do @(posedge clk); while (!s_tready);
		sent_items++;
	endtask

	// stop offering and let every outstanding result drain, plus the output latency
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// APB write: setup cycle, access cycle, then back to idle
	task automatic write_reg(input logic [2:0] idx, input int val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(input int thr, input int deb, input int min_up, input int delta,
			input int ef, input int eb, input int xf, input int xb);
		write_reg(REG_PRESSURE_THRESHOLD, thr);
		write_reg(REG_DEBOUNCE_SAMPLES, deb);
		write_reg(REG_MIN_UPTIME, min_up);
		write_reg(REG_EROSION_DELTA, delta);
		write_reg(REG_COMPACT_ENTER_FREE, ef);
		write_reg(REG_COMPACT_ENTER_BLOCK, eb);
		write_reg(REG_COMPACT_EXIT_FREE, xf);
		write_reg(REG_COMPACT_EXIT_BLOCK, xb);
		cfg_thr = thr;
		cfg_deb = deb;
		cfg_min = min_up;
		cfg_enter_free = ef;
		cfg_enter_block = eb;
		cfg_exit_free = xf;
		cfg_exit_block = xb;
	endtask

	function automatic logic [16:0] clamp17(input int v);
		if (v < 0)
			return 17'd0;
		if (v > 131071)
			return 17'h1FFFF;
		return v[16:0];
	endfunction

	// a value within a few hundred of a hysteresis threshold
	function automatic logic [16:0] near(input int center);
		return clamp17(center + int'($urandom_range(0, 600)) - 300);
	endfunction

	// mostly a reading below the pressure threshold, sometimes on it or anywhere
	function automatic logic [16:0] low_block();
		if (cfg_thr == 0 || $urandom_range(0, 9) == 0)
			return 17'($urandom_range(0, 131071));
		if ($urandom_range(0, 9) == 0)
			return 17'(cfg_thr);
		return 17'($urandom_range(0, cfg_thr - 1));
	endfunction

	// mostly an uptime past every gate, with edges of the uptime and burst gates
	function automatic logic [31:0] check_uptime(input logic pri);
		case ($urandom_range(0, 7))
			0: return 32'((cfg_min > 0) ? cfg_min - 1 : 0);
			1: return 32'(BURST_SUPPRESS_S - 1 + $urandom_range(0, 1));
			2: return $urandom();
			default: return 32'(cfg_min + $urandom_range(0, 20000) +
				(pri ? BURST_SUPPRESS_S : 0));
		endcase
	endfunction

	// well-formed: maybe flush, a trend of samples with heartbeats, then a run of checks
	task automatic erosion_run();
		int n_samples, n_checks, level, slope, i;
		logic pri;
		if ($urandom_range(0, 2) == 0)
			push_event(FUNC_FLUSH, 17'($urandom_range(0, 131071)),
				17'($urandom_range(0, 131071)), $urandom(), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		n_samples = $urandom_range(1, 14);
		level = $urandom_range(0, 90000);
		slope = int'($urandom_range(0, 4000)) - 3000;
		for (i = 0; i < n_samples; i++) begin
			push_event(FUNC_SAMPLE,
				clamp17(level + slope * i + int'($urandom_range(0, 400)) - 200),
				17'($urandom_range(0, 131071)), $urandom(), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
			if ($urandom_range(0, 7) == 0)
				push_event(FUNC_HEARTBEAT, near(cfg_enter_block), near(cfg_enter_free),
					$urandom(), 1'b0, 1'b0);
		end
		n_checks = $urandom_range(1, cfg_deb + 3);
		for (i = 0; i < n_checks; i++) begin
			pri = ($urandom_range(0, 3) == 0);
			push_event(FUNC_CHECK, low_block(), 17'($urandom_range(0, 131071)),
				check_uptime(pri), $urandom_range(0, 15) == 0, pri);
		end
	endtask

	// heartbeats around the enter and exit thresholds of the compact latch
	task automatic compact_run();
		int n, i;
		logic [16:0] f, b;
		n = $urandom_range(2, 8);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 1)) begin
				f = near(cfg_enter_free);
				b = near(cfg_enter_block);
			end else begin
				f = near(cfg_exit_free);
				b = near(cfg_exit_block);
			end
			if ($urandom_range(0, 3) == 0)
				f = 17'($urandom_range(0, 131071));
			push_event(FUNC_HEARTBEAT, b, f, $urandom(), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		end
	endtask

	task automatic run_phase(input int n);
		int target, pick;
		target = sent_items + n;
		while (sent_items < target) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				erosion_run();
			end else if (pick < 8) begin
				compact_run();
			end else begin
				// noise: any kind, every field drawn over its full range
				push_event(2'($urandom_range(0, 3)), 17'($urandom_range(0, 131071)),
					17'($urandom_range(0, 131071)), $urandom(),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = FUNC_SAMPLE;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_thr = int'(RST_PRESSURE_THRESHOLD);
		cfg_deb = int'(RST_DEBOUNCE_SAMPLES);
		cfg_min = int'(RST_MIN_UPTIME);
		cfg_enter_free = int'(RST_COMPACT_ENTER_FREE);
		cfg_enter_block = int'(RST_COMPACT_ENTER_BLOCK);
		cfg_exit_free = int'(RST_COMPACT_EXIT_FREE);
		cfg_exit_block = int'(RST_COMPACT_EXIT_BLOCK);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part on the reset settings
		// compact latch: enter on zero readings, stay just below exit, exit on the edge
		push_event(FUNC_HEARTBEAT, 17'd0, 17'd0, 32'd0, 1'b0, 1'b0);
		push_event(FUNC_HEARTBEAT, 17'd15023, 17'd21024, 32'd0, 1'b0, 1'b0);
		push_event(FUNC_HEARTBEAT, 17'd15024, 17'd21024, 32'd0, 1'b0, 1'b0);
		push_event(FUNC_HEARTBEAT, 17'h1FFFF, 17'd19999, 32'd0, 1'b0, 1'b0);
		push_event(FUNC_HEARTBEAT, 17'h1FFFF, 17'h1FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
		push_event(FUNC_HEARTBEAT, 17'd14000, 17'd20000, 32'd0, 1'b0, 1'b0);
		// gated checks: uptime too short, recovery mode, burst after a proactive boot
		push_event(FUNC_CHECK, 17'd0, 17'd0, 32'd1799, 1'b0, 1'b0);
		push_event(FUNC_CHECK, 17'd0, 17'd0, 32'hFFFF_FFFF, 1'b1, 1'b0);
		push_event(FUNC_CHECK, 17'd0, 17'd0, 32'd14399, 1'b0, 1'b1);
		// healthy reading right on the threshold
		push_event(FUNC_CHECK, 17'd13000, 17'd0, 32'd1800, 1'b0, 1'b0);
		// debounce up to the limit, then fire with too few samples in the ring
		push_event(FUNC_CHECK, 17'd0, 17'd0, 32'd14400, 1'b0, 1'b1);
		push_event(FUNC_CHECK, 17'd0, 17'd0, 32'd14400, 1'b0, 1'b1);
		push_event(FUNC_CHECK, 17'd0, 17'd0, 32'd14400, 1'b0, 1'b1);
		push_event(FUNC_CHECK, 17'd12999, 17'd0, 32'd1800, 1'b0, 1'b0);
		// falling trend, first reading saturates to 16 bits
		push_event(FUNC_SAMPLE, 17'h1FFFF, 17'h1FFFF, 32'd0, 1'b0, 1'b0);
		push_event(FUNC_SAMPLE, 17'd65535, 17'd0, 32'd0, 1'b0, 1'b0);
		push_event(FUNC_SAMPLE, 17'd60000, 17'd0, 32'd0, 1'b0, 1'b0);
		push_event(FUNC_SAMPLE, 17'd50000, 17'd0, 32'd0, 1'b0, 1'b0);
		push_event(FUNC_SAMPLE, 17'd30000, 17'd0, 32'd0, 1'b0, 1'b0);
		push_event(FUNC_SAMPLE, 17'd0, 17'd0, 32'd0, 1'b0, 1'b0);
		// real erosion: fires
		push_event(FUNC_CHECK, 17'd0, 17'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
		// drop one short of the delta: not eroding, count cleared
		push_event(FUNC_SAMPLE, 17'd64512, 17'd0, 32'd0, 1'b0, 1'b0);
		push_event(FUNC_CHECK, 17'd0, 17'd0, 32'd1800, 1'b0, 1'b0);
		push_event(FUNC_FLUSH, 17'h1FFFF, 17'h1FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
		push_event(FUNC_CHECK, 17'd0, 17'd0, 32'd1800, 1'b0, 1'b0);
		drain();

		// random phases: all zero, all maximum, three drawn settings, back to defaults
		set_config(0, 0, 0, 0, 0, 0, 0, 0);
		run_phase(200);
		drain();
		set_config(65535, 15, 65535, 65535, 131071, 131071, 131071, 131071);
		run_phase(200);
		repeat (3) begin
			drain();
			set_config($urandom_range(2000, 40000), $urandom_range(0, 5),
				$urandom_range(0, 5000), $urandom_range(0, 5000),
				$urandom_range(0, 131071), $urandom_range(0, 131071),
				$urandom_range(0, 131071), $urandom_range(0, 131071));
			run_phase(220);
		end
		drain();
		set_config(int'(RST_PRESSURE_THRESHOLD), int'(RST_DEBOUNCE_SAMPLES),
			int'(RST_MIN_UPTIME), int'(RST_EROSION_DELTA),
			int'(RST_COMPACT_ENTER_FREE), int'(RST_COMPACT_ENTER_BLOCK),
			int'(RST_COMPACT_EXIT_FREE), int'(RST_COMPACT_EXIT_BLOCK));
		run_phase(200);

		// wait for every outstanding result, then the verdict
		drain();
		repeat (6) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+src
src/hprm_pkg.sv
src/hprm_cell.sv
src/hprm_skid.sv
src/heap_pressure_restart_monitor.sv
dv/hprm_result_checker.sv
dv/tb_top.sv
